@@ rtl/core/dna_pkg.sv @@
// Package for the dial needle angle block: payload structs, widths, constants
// and the CORDIC arctangent table. Depends on nothing.
package dna_pkg;

	localparam int COORD_BITS  = 11;
	localparam int RADIUS_BITS = 10;
	localparam int ROI_BITS    = 11;
	localparam int ANGLE_BITS  = 15;
	localparam logic [ROI_BITS-1:0] ROI_RESET = 11'd200;
	localparam int CORDIC_STEPS = 16;
	localparam int PRESCALE_SH  = 8;
	localparam int FULL_TURN_64 = 23040;
	localparam int REG_ROI_WIDTH = 0;

	typedef struct packed {
		logic [COORD_BITS-1:0]  seg_x1;
		logic [COORD_BITS-1:0]  seg_y1;
		logic [COORD_BITS-1:0]  seg_x2;
		logic [COORD_BITS-1:0]  seg_y2;
		logic [COORD_BITS-1:0]  dial_x;
		logic [COORD_BITS-1:0]  dial_y;
		logic [RADIUS_BITS-1:0] dial_radius;
	} seg_t;

	typedef struct packed {
		logic                  accepted;
		logic [ANGLE_BITS-1:0] angle;
		logic                  on_left;
	} res_t;

	// atan(2^-i) in units of 2^-16 degree, rounded to nearest.
	function automatic logic [21:0] atan_step(input logic [3:0] i);
		logic [21:0] v;
		unique case (i)
			4'd0:  v = 22'd2949120;
			4'd1:  v = 22'd1740967;
			4'd2:  v = 22'd919879;
			4'd3:  v = 22'd466945;
			4'd4:  v = 22'd234379;
			4'd5:  v = 22'd117304;
			4'd6:  v = 22'd58666;
			4'd7:  v = 22'd29335;
			4'd8:  v = 22'd14668;
			4'd9:  v = 22'd7334;
			4'd10: v = 22'd3667;
			4'd11: v = 22'd1833;
			4'd12: v = 22'd917;
			4'd13: v = 22'd458;
			4'd14: v = 22'd229;
			default: v = 22'd115;
		endcase
		return v;
	endfunction

endpackage

@@ rtl/core/dial_needle_angle.sv @@
// Top level of the dial needle angle block: geometry checks and a pipelined
// CORDIC. Depends on dna_pkg.
//
// Usage: one segment and one dial circle arrive as a transfer on the seg
// channel (seg_valid high, seg_stall low at a rising edge). Exactly one result
// leaves as a transfer on the res channel for every input transfer, in order.
// The block takes one transfer per cycle while no valid result is stalled.
// Between the input transfer and res_valid lie one stage of differences, one
// of squares and the cross product, two of compares and tip selection,
// sixteen CORDIC vectoring stages, and one stage that wraps and rounds the
// angle into the output register. Throughput is set by the CORDIC being
// fully unrolled, one iteration per stage.
// When the receiver stalls a valid result, the whole pipeline holds and
// seg_stall rises in the same cycle, so nothing is lost or repeated; bubbles
// in the pipeline do not stall the input while the output is empty.
// Reset clears every valid bit and sets roi_width to 200. The APB port holds
// the single register roi_width at byte address 0; pready is always high.
module dial_needle_angle (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [2:0]         paddr,
	input  logic [31:0]        pwdata,
	output logic [31:0]        prdata,
	output logic               pready,
	input  logic               seg_valid,
	output logic               seg_stall,
	input  dna_pkg::seg_t      seg,
	output logic               res_valid,
	input  logic               res_stall,
	output dna_pkg::res_t      res
);

	localparam int C     = dna_pkg::COORD_BITS;
	localparam int N     = dna_pkg::CORDIC_STEPS;
	localparam int DW    = 2 * C + 3;              // squares and cross, signed
	localparam int W     = C + dna_pkg::PRESCALE_SH + 3; // CORDIC x/y, signed
	localparam int ZW    = 27;                      // angle accumulator, signed
	localparam int DEPTH = N + 5;                   // stages including output

	// Configuration register.
	logic [dna_pkg::ROI_BITS-1:0] roi_width_q;
	logic                         cfg_hit;

	assign pready  = 1'b1;
	assign cfg_hit = (paddr[2] == 1'(dna_pkg::REG_ROI_WIDTH));
	assign prdata  = cfg_hit ? 32'(roi_width_q) : 32'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			roi_width_q <= dna_pkg::ROI_RESET;
		end else if (psel && penable && pwrite && cfg_hit) begin
			roi_width_q <= pwdata[dna_pkg::ROI_BITS-1:0];
		end
	end

	// The whole pipeline advances together unless a held result is stalled.
	logic en;
	logic vld_s [DEPTH];

	assign en        = !vld_s[DEPTH-1] || !res_stall;
	assign seg_stall = !en;
	assign res_valid = vld_s[DEPTH-1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < DEPTH; i++) vld_s[i] <= 1'b0;
		end else if (en) begin
			vld_s[0] <= seg_valid;
			for (int i = 1; i < DEPTH; i++) vld_s[i] <= vld_s[i-1];
		end
	end

	// Stage 1: offsets from the centre and the segment direction.
	logic signed [C:0] dx1_s1, dy1_s1, dx2_s1, dy2_s1, sx_s1, sy_s1;
	logic [dna_pkg::RADIUS_BITS-1:0] r_s1;
	logic left_s1;

	always_ff @(posedge clk) begin
		if (en) begin
			dx1_s1  <= $signed({1'b0, seg.seg_x1}) - $signed({1'b0, seg.dial_x});
			dy1_s1  <= $signed({1'b0, seg.seg_y1}) - $signed({1'b0, seg.dial_y});
			dx2_s1  <= $signed({1'b0, seg.seg_x2}) - $signed({1'b0, seg.dial_x});
			dy2_s1  <= $signed({1'b0, seg.seg_y2}) - $signed({1'b0, seg.dial_y});
			sx_s1   <= $signed({1'b0, seg.seg_x2}) - $signed({1'b0, seg.seg_x1});
			sy_s1   <= $signed({1'b0, seg.seg_y2}) - $signed({1'b0, seg.seg_y1});
			r_s1    <= seg.dial_radius;
			left_s1 <= ({seg.dial_x, 1'b0} < (C + 1)'(roi_width_q));
		end
	end

	// Stage 2: squared distances, squared radius and length, cross product.
	logic signed [DW-1:0] d1_s2, d2_s2, len2_s2, cross_s2;
	logic [2*dna_pkg::RADIUS_BITS-1:0] r2_s2;
	logic signed [C:0] dx1_s2, dy1_s2, dx2_s2, dy2_s2;
	logic left_s2;

	always_ff @(posedge clk) begin
		if (en) begin
			d1_s2    <= DW'(dx1_s1 * dx1_s1) + DW'(dy1_s1 * dy1_s1);
			d2_s2    <= DW'(dx2_s1 * dx2_s1) + DW'(dy2_s1 * dy2_s1);
			len2_s2  <= DW'(sx_s1 * sx_s1) + DW'(sy_s1 * sy_s1);
			cross_s2 <= DW'(sx_s1 * dy1_s1) - DW'(dx1_s1 * sy_s1);
			r2_s2    <= r_s1 * r_s1;
			dx1_s2   <= dx1_s1;
			dy1_s2   <= dy1_s1;
			dx2_s2   <= dx2_s1;
			dy2_s2   <= dy2_s1;
			left_s2  <= left_s1;
		end
	end

	// Stage 3: circle test, squares for the line distance, tip selection.
	logic [DW-1:0]   cabs;
	logic [2*DW-1:0] csq_s3, lprod_s3;
	logic            inside_s3, big_s3, nz_s3, left_s3;
	logic signed [C:0] vx_s3, vy_s3;

	assign cabs = cross_s2[DW-1] ? DW'(-cross_s2) : DW'(cross_s2);

	always_ff @(posedge clk) begin
		if (en) begin
			inside_s3 <= (64'(d1_s2) * 64'd100 < 64'(r2_s2) * 64'd169)
				&& (64'(d2_s2) * 64'd100 < 64'(r2_s2) * 64'd169);
			big_s3    <= (64'(cabs) >= (64'd1 << 27));
			nz_s3     <= (len2_s2 != '0);
			csq_s3    <= cabs * cabs;
			lprod_s3  <= (2 * DW)'(r2_s2) * (2 * DW)'(len2_s2);
			// Equal distances take the second endpoint as the tip.
			if (d1_s2 > d2_s2) begin
				vx_s3 <= dx1_s2;
				vy_s3 <= -dy1_s2;
			end else begin
				vx_s3 <= dx2_s2;
				vy_s3 <= -dy2_s2;
			end
			left_s3 <= left_s2;
		end
	end

	// Stage 4: line distance test and CORDIC pre-rotation into the right
	// half plane. The cor_* arrays are indexed by CORDIC step.
	logic signed [W-1:0]  cor_x_s [N+1];
	logic signed [W-1:0]  cor_y_s [N+1];
	logic signed [ZW-1:0] cor_z_s [N+1];
	logic                 cor_ok_s [N+1];
	logic                 cor_left_s [N+1];
	logic signed [W-1:0]  px, py;

	assign px = W'(vx_s3) <<< dna_pkg::PRESCALE_SH;
	assign py = W'(vy_s3) <<< dna_pkg::PRESCALE_SH;

	always_ff @(posedge clk) begin
		if (en) begin
			cor_ok_s[0]   <= inside_s3 && nz_s3 && !big_s3
				&& (64'(csq_s3) * 64'd25 < 64'(lprod_s3));
			cor_left_s[0] <= left_s3;
			if (px < 0) begin
				cor_x_s[0] <= -px;
				cor_y_s[0] <= -py;
				cor_z_s[0] <= ZW'(180 * 65536);
			end else begin
				cor_x_s[0] <= px;
				cor_y_s[0] <= py;
				cor_z_s[0] <= '0;
			end
		end
	end

	// Stages 5 to 20: one vectoring iteration per stage.
	for (genvar k = 0; k < N; k++) begin : g_cordic
		logic signed [W-1:0]  xs, ys;
		logic signed [ZW-1:0] az;

		assign xs = cor_x_s[k] >>> k;
		assign ys = cor_y_s[k] >>> k;
		assign az = ZW'(dna_pkg::atan_step(4'(k)));

		always_ff @(posedge clk) begin
			if (en) begin
				if (cor_y_s[k] >= 0) begin
					cor_x_s[k+1] <= cor_x_s[k] + ys;
					cor_y_s[k+1] <= cor_y_s[k] - xs;
					cor_z_s[k+1] <= cor_z_s[k] + az;
				end else begin
					cor_x_s[k+1] <= cor_x_s[k] - ys;
					cor_y_s[k+1] <= cor_y_s[k] + xs;
					cor_z_s[k+1] <= cor_z_s[k] - az;
				end
				cor_ok_s[k+1]   <= cor_ok_s[k];
				cor_left_s[k+1] <= cor_left_s[k];
			end
		end
	end

	// Output stage: wrap into one turn and round half up to 1/64 degree.
	localparam int ANGLE_W = dna_pkg::ANGLE_BITS;
	logic signed [ZW-1:0] zw, zr;
	logic [ANGLE_W-1:0]   tr;

	assign zw = (cor_z_s[N] < 0) ? cor_z_s[N] + ZW'(360 * 65536) : cor_z_s[N];
	assign zr = (zw + ZW'(512)) >>> 10;
	assign tr = (zr >= ZW'(dna_pkg::FULL_TURN_64))
		? ANGLE_W'(zr - ZW'(dna_pkg::FULL_TURN_64)) : ANGLE_W'(zr);

	always_ff @(posedge clk) begin
		if (en) begin
			res.accepted <= cor_ok_s[N];
			res.angle    <= cor_ok_s[N] ? tr : '0;
			res.on_left  <= cor_left_s[N];
		end
	end

endmodule

@@ rtl/core/dna_checker.sv @@
// Port-level checker for the dial needle angle block and its bind.
// Depends on dna_pkg and dial_needle_angle.
module dna_checker (
	input logic          clk,
	input logic          arst_n,
	input logic          seg_stall,
	input logic          res_valid,
	input logic          res_stall,
	input dna_pkg::res_t res
);

	// A stalled result holds its value.
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_stall |=> res_valid && $stable(res))
		else $error("stalled result changed");

	// The input is held off exactly while a valid result is stalled.
	a_stall: assert property (@(posedge clk) disable iff (!arst_n)
		seg_stall == (res_valid && res_stall))
		else $error("input stall does not follow output stall");

	// A rejected segment carries a zero angle.
	a_rej: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res.accepted |-> res.angle == '0)
		else $error("rejected result has nonzero angle");

	// The angle stays below a full turn.
	a_range: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> res.angle < 15'(dna_pkg::FULL_TURN_64))
		else $error("angle out of range");

endmodule

bind dial_needle_angle dna_checker u_dna_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.seg_stall (seg_stall),
	.res_valid (res_valid),
	.res_stall (res_stall),
	.res       (res)
);

@@ tb/tb_dial_needle_angle.sv @@
// Self-checking testbench for dial_needle_angle: drives segment/dial pairs,
// predicts each result in SystemVerilog and checks it. Depends on dna_pkg and dial_needle_angle.
module tb_dial_needle_angle;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int SEG_W = $bits(dna_pkg::seg_t);

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
	logic [2:0] paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic pready;
	logic seg_valid = 1'b0;
	logic seg_stall;
	dna_pkg::seg_t seg = '0;
	logic res_valid;
	logic res_stall = 1'b0;
	dna_pkg::res_t res;

	dial_needle_angle i_dut (.*);

	// Clock with an 8 ns period.
	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	dna_pkg::seg_t pending_segs[$];
	dna_pkg::res_t expected_results[$];
	logic [dna_pkg::ROI_BITS-1:0] roi_model = dna_pkg::ROI_RESET;
	int errors = 0;
	int seg_idle_pct = 0;
	int res_idle_pct = 0;
	int hold_cycles = 0;
	longint cycles = 0;
	logic seg_taken = 1'b0;

	task automatic add_pending(input dna_pkg::seg_t s);
		pending_segs.insert(pending_segs.size(), s);
	endtask

	task automatic add_expected(input dna_pkg::res_t r);
		expected_results.insert(expected_results.size(), r);
	endtask

	// Angle of the vector (vx, vy), y pointing up, in 1/64 degree.
	function automatic logic [dna_pkg::ANGLE_BITS-1:0] needle_angle(longint vx,
		longint vy);
		longint x, y, z, xs, ys, t;
		longint steps[16] = '{2949120, 1740967, 919879, 466945, 234379, 117304,
			58666, 29335, 14668, 7334, 3667, 1833, 917, 458, 229, 115};
		x = vx * 256;
		y = vy * 256;
		z = 0;
		if (x < 0) begin
			x = -x;
			y = -y;
			z = 180 * 65536;
		end
		for (int i = 0; i < dna_pkg::CORDIC_STEPS; i++) begin
			// >>> on a signed longint is a floor shift.
			xs = x >>> i;
			ys = y >>> i;
			if (y >= 0) begin
				x = x + ys;
				y = y - xs;
				z = z + steps[i];
			end else begin
				x = x - ys;
				y = y + xs;
				z = z - steps[i];
			end
		end
		if (z < 0)
			z += 360 * 65536;
		t = (z + 512) >>> 10;
		if (t >= dna_pkg::FULL_TURN_64)
			t -= dna_pkg::FULL_TURN_64;
		return t[dna_pkg::ANGLE_BITS-1:0];
	endfunction

	// Needle test and tip angle for one segment against one dial.
	function automatic dna_pkg::res_t judge_needle(dna_pkg::seg_t s);
		dna_pkg::res_t r;
		longint dx1, dy1, dx2, dy2, sx, sy, d1, d2, r2, len2, cr;
		logic ok;
		dx1 = longint'(s.seg_x1) - longint'(s.dial_x);
		dy1 = longint'(s.seg_y1) - longint'(s.dial_y);
		dx2 = longint'(s.seg_x2) - longint'(s.dial_x);
		dy2 = longint'(s.seg_y2) - longint'(s.dial_y);
		sx = longint'(s.seg_x2) - longint'(s.seg_x1);
		sy = longint'(s.seg_y2) - longint'(s.seg_y1);
		d1 = dx1 * dx1 + dy1 * dy1;
		d2 = dx2 * dx2 + dy2 * dy2;
		r2 = longint'(s.dial_radius) * longint'(s.dial_radius);
		len2 = sx * sx + sy * sy;
		cr = sx * dy1 - dx1 * sy;
		if (cr < 0)
			cr = -cr;
		ok = (100 * d1 < 169 * r2) && (100 * d2 < 169 * r2) && (cr < (64'sd1 <<< 27))
			&& (25 * cr * cr < r2 * len2) && (len2 != 0);
		r.accepted = ok;
		r.angle = '0;
		if (ok)
			r.angle = (d1 > d2) ? needle_angle(dx1, -dy1) : needle_angle(dx2, -dy2);
		r.on_left = ({1'b0, s.dial_x, 1'b0} < {2'b0, roi_model});
		return r;
	endfunction

	// Records whether the offered segment was taken at this rising edge.
	always @(posedge clk)
		seg_taken <= seg_valid && !seg_stall;

	// Driver: offers the next pending segment; a new one replaces it only
	// after the current transfer completes.
	always @(negedge clk) begin
		if (arst_n) begin
			if (!seg_valid || seg_taken) begin
				if (pending_segs.size() != 0 && $urandom_range(99) >= seg_idle_pct) begin
					seg <= pending_segs[0];
					seg_valid <= 1'b1;
					add_expected(judge_needle(pending_segs.pop_front()));
				end else begin
					seg_valid <= 1'b0;
				end
			end
			res_stall <= (hold_cycles > 0) || ($urandom_range(99) < res_idle_pct);
		end
	end

	// Long receiver hold-off, counted down in its own process.
	always @(posedge clk)
		if (hold_cycles > 0)
			hold_cycles <= hold_cycles - 1;

	// Monitor: compares each result transfer with the oldest expectation.
	always @(posedge clk) begin
		dna_pkg::res_t want;
		cycles <= cycles + 1;
		if (arst_n && res_valid && !res_stall) begin
			if (expected_results.size() == 0) begin
				$error("result with no expectation waiting");
				errors++;
			end else begin
				want = expected_results.pop_front();
				if (res.accepted !== want.accepted) begin
					$error("accepted: expected %0d, got %0d", want.accepted, res.accepted);
					errors++;
				end
				if (res.angle !== want.angle) begin
					$error("angle: expected %0d, got %0d", want.angle, res.angle);
					errors++;
				end
				if (res.on_left !== want.on_left) begin
					$error("on_left: expected %0d, got %0d", want.on_left, res.on_left);
					errors++;
				end
			end
		end
	end

	// Timeout watchdog.
	always @(posedge clk)
		if (cycles > 400000) begin
			$display("TB_ERROR");
			$finish;
		end

	task automatic write_roi(input logic [dna_pkg::ROI_BITS-1:0] w);
		@(negedge clk);
		psel <= 1'b1;
		pwrite <= 1'b1;
		paddr <= 3'(dna_pkg::REG_ROI_WIDTH * 4);
		pwdata <= 32'(w);
		@(negedge clk);
		penable <= 1'b1;
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		roi_model = w;
	endtask

	task automatic drain;
		while (pending_segs.size() != 0 || expected_results.size() != 0)
			@(posedge clk);
		repeat (30) @(posedge clk);
	endtask

	// A needle-like segment: near endpoint around the center, tip up to one radius out along an axis.
	function automatic dna_pkg::seg_t needle_seg();
		dna_pkg::seg_t s;
		int r, ang, px, py;
		s.dial_radius = ($urandom_range(9) == 0) ? 10'($urandom_range(1023))
			: 10'($urandom_range(200, 10));
		r = s.dial_radius;
		s.dial_x = 11'($urandom_range(2047 - r - r / 3, r + r / 3));
		s.dial_y = 11'($urandom_range(2047 - r - r / 3, r + r / 3));
		px = $urandom_range(r / 8);
		py = $urandom_range(r / 8);
		ang = $urandom_range(r);
		s.seg_x1 = 11'(int'(s.dial_x) + px - r / 16);
		s.seg_y1 = 11'(int'(s.dial_y) + py - r / 16);
		// Tip placed on one of four sides, with a random lateral offset.
		case ($urandom_range(3))
			0: begin s.seg_x2 = 11'(int'(s.dial_x) + ang); s.seg_y2 = 11'(int'(s.dial_y) + py); end
			1: begin s.seg_x2 = 11'(int'(s.dial_x) - ang); s.seg_y2 = 11'(int'(s.dial_y) - py); end
			2: begin s.seg_y2 = 11'(int'(s.dial_y) + ang); s.seg_x2 = 11'(int'(s.dial_x) - px); end
			default: begin s.seg_y2 = 11'(int'(s.dial_y) - ang); s.seg_x2 = 11'(int'(s.dial_x) + px); end
		endcase
		if ($urandom_range(1)) begin
			{s.seg_x1, s.seg_x2} = {s.seg_x2, s.seg_x1};
			{s.seg_y1, s.seg_y2} = {s.seg_y2, s.seg_y1};
		end
		return s;
	endfunction

	task automatic random_batch(input int n);
		for (int i = 0; i < n; i++)
			add_pending(($urandom_range(3) == 0)
				? dna_pkg::seg_t'(SEG_W'({$urandom, $urandom, $urandom}))
				: needle_seg());
	endtask

	function automatic dna_pkg::seg_t mk(int x1, int y1, int x2, int y2, int cx, int cy,
		int r);
		dna_pkg::seg_t s;
		s = '{11'(x1), 11'(y1), 11'(x2), 11'(y2), 11'(cx), 11'(cy), 10'(r)};
		return s;
	endfunction

	initial begin
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Directed: axis tips, degenerate, zero radius, equal distances,
		// field extremes and the on_left boundary at the reset width.
		add_pending(mk(100, 100, 150, 100, 100, 100, 50));
		add_pending(mk(100, 100, 100, 50, 100, 100, 50));
		add_pending(mk(100, 100, 50, 100, 100, 100, 50));
		add_pending(mk(100, 100, 100, 150, 100, 100, 50));
		add_pending(mk(100, 150, 100, 100, 100, 100, 50));
		add_pending(mk(130, 140, 100, 100, 100, 100, 50));
		add_pending(mk(100, 100, 100, 100, 100, 100, 50));
		add_pending(mk(100, 100, 110, 100, 100, 100, 0));
		add_pending(mk(90, 100, 110, 100, 100, 100, 50));
		add_pending(mk(100, 90, 100, 110, 100, 100, 50));
		add_pending(mk(0, 0, 2047, 2047, 1023, 1023, 1023));
		add_pending(mk(2047, 2047, 0, 0, 1024, 1024, 1023));
		add_pending(mk(2047, 0, 0, 2047, 0, 2047, 1023));
		add_pending(mk(99, 99, 101, 101, 99, 100, 1023));
		add_pending(mk(100, 100, 165, 100, 100, 100, 50));
		add_pending(mk(100, 100, 164, 100, 100, 100, 50));
		add_pending(mk(100, 110, 140, 110, 100, 100, 50));
		add_pending(mk(100, 100, 141, 99, 100, 100, 50));
		add_pending(mk(100, 100, 141, 101, 100, 100, 50));
		add_pending(mk(5, 5, 6, 5, 5, 5, 1));
		add_pending(mk(100, 100, 150, 100, 99, 100, 50));
		add_pending(mk(100, 100, 150, 100, 100, 100, 50));
		drain();

		// Sender idles little, receiver often, with one long hold-off.
		seg_idle_pct = 6;
		res_idle_pct = 72;
		hold_cycles = 120;
		write_roi(11'd1);
		random_batch(230);
		drain();

		seg_idle_pct = 72;
		res_idle_pct = 6;
		write_roi(11'd2047);
		random_batch(230);
		drain();

		seg_idle_pct = 0;
		res_idle_pct = 0;
		write_roi(11'($urandom_range(2047, 1)));
		random_batch(120);
		drain();
		write_roi(11'd0);
		random_batch(120);
		drain();

		if (errors == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end
endmodule

@@ dial_needle_angle.f @@
rtl/core/dna_pkg.sv
rtl/core/dial_needle_angle.sv
rtl/core/dna_checker.sv
tb/tb_dial_needle_angle.sv
